@@ design/smas_pkg.sv @@
`timescale 1ns / 1ps

package smas_pkg;

    localparam int MATRIX_SIZE = 4;
    localparam int ELEM_COUNT  = MATRIX_SIZE * MATRIX_SIZE;
    localparam int IDX_W       = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
    localparam int ADDR_W      = $clog2(ELEM_COUNT);

    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int TERM_W      = PROD_W + 1;
    localparam int RESULT_W    = 35;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OCC_W       = $clog2(OUTQ_DEPTH + 1);

    localparam int OP_W        = 2;
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam int REG_ADDR_W  = 3;
    localparam logic [0:0] REG_OPERATION = 1'b0;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_CALC
    } seq_state_t;

    // Tag that travels alongside each operand pair through the datapath.
    typedef struct packed {
        logic            valid;
        logic            first;
        logic            k_last;
        logic            elem_last;
        logic [OP_W-1:0] op;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
    } issue_t;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [RESULT_W-1:0] value;
    } result_t;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MATRIX_SIZE + int'(col));
    endfunction

endpackage

@@ design/smas_ram.sv @@
`timescale 1ns / 1ps

module smas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/smas_seq.sv @@
`timescale 1ns / 1ps

module smas_seq
    import smas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic              pop,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output issue_t            issue
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] load_count_reg, load_count_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic accept, last_pair, is_mul, elem_start, k_end, row_end, col_end, go, all_done;

    assign accept     = in_valid && in_ready;
    assign last_pair  = (load_count_reg == ADDR_W'(ELEM_COUNT - 1));
    assign is_mul     = !((op_reg == OP_ADD) || (op_reg == OP_SUB));
    assign elem_start = (k_reg == '0);
    assign k_end      = !is_mul || (k_reg == IDX_W'(MATRIX_SIZE - 1));
    assign col_end    = (j_reg == IDX_W'(MATRIX_SIZE - 1));
    assign row_end    = (i_reg == IDX_W'(MATRIX_SIZE - 1));
    // A new element needs a free slot in the output queue; continuing one does not.
    assign go         = (state_reg == ST_CALC) &&
                        (!elem_start || (occ_reg < OCC_W'(OUTQ_DEPTH)));
    assign all_done   = go && k_end && col_end && row_end;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && last_pair) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (all_done) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        in_ready            = 1'b0;
        issue.tag.valid     = 1'b0;
        case (state_reg)
            ST_LOAD: in_ready        = 1'b1;
            ST_CALC: issue.tag.valid = go;
            default: in_ready        = 1'b0;
        endcase
        wr_en               = accept;
        wr_addr             = load_count_reg;
        issue.tag.first     = elem_start;
        issue.tag.k_last    = k_end;
        issue.tag.elem_last = col_end && row_end;
        issue.tag.op        = op_reg;
        issue.a_addr        = is_mul ? elem_addr(i_reg, k_reg) : elem_addr(i_reg, j_reg);
        issue.b_addr        = is_mul ? elem_addr(k_reg, j_reg) : elem_addr(i_reg, j_reg);
    end

    // Load counter, operation latch, loop indexes and queue occupancy.
    always_comb begin
        load_count_next = load_count_reg;
        op_next         = op_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        occ_next        = occ_reg;
        if (accept) begin
            if (last_pair) begin
                load_count_next = '0;
                op_next         = operation;
            end else begin
                load_count_next = load_count_reg + 1'b1;
            end
        end
        if (go) begin
            if (k_end) begin
                k_next = '0;
                if (col_end) begin
                    j_next = '0;
                    i_next = row_end ? '0 : i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end else begin
                k_next = k_reg + 1'b1;
            end
        end
        case ({go && elem_start, pop})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            op_reg         <= OP_ADD;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            occ_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            op_reg         <= op_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            occ_reg        <= occ_next;
        end
    end

endmodule

@@ design/smas_dp.sv @@
`timescale 1ns / 1ps

module smas_dp
    import smas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tag_t              tag_in,
    input  logic [ELEM_W-1:0] a_q,
    input  logic [ELEM_W-1:0] b_q,
    output result_t           result
);

    tag_t                       tag1_reg, tag2_reg;
    logic signed [TERM_W-1:0]   term_reg, term_next;
    logic signed [RESULT_W-1:0] acc_reg, acc_next;
    logic                       res_valid_reg, res_last_reg;
    logic signed [ELEM_W-1:0]   a_s, b_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [RESULT_W-1:0] term_ext;

    assign a_s  = $signed(a_q);
    assign b_s  = $signed(b_q);
    assign prod = a_s * b_s;

    // The one shared unit: multiply for the product, add or subtract otherwise.
    always_comb begin
        case (tag1_reg.op)
            OP_ADD:  term_next = TERM_W'(a_s) + TERM_W'(b_s);
            OP_SUB:  term_next = TERM_W'(a_s) - TERM_W'(b_s);
            default: term_next = TERM_W'(prod);
        endcase
    end

    assign term_ext = RESULT_W'(term_reg);
    assign acc_next = tag2_reg.first ? term_ext : acc_reg + term_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            res_valid_reg <= tag2_reg.valid && tag2_reg.k_last;
        end
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
        if (tag2_reg.valid) begin
            acc_reg      <= acc_next;
            res_last_reg <= tag2_reg.elem_last;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.last  = res_last_reg;
    assign result.value = acc_reg;

endmodule

@@ design/square_matrix_add_sub_mul.sv @@
`timescale 1ns / 1ps

// Square matrix add, subtract and multiply.
//
// Each input transaction on the s_ channel carries one pair of same-position
// elements of matrices A and B, in row-major order. The load takes one
// transaction per cycle. After the last pair of a load, s_tready drops while
// the sequencer walks the result matrix, and the results leave in row-major
// order on the m_ channel, with m_tlast on the final element.
// The operation register (APB, byte address 0) selects A+B, A-B or the
// product A x B; the value in effect when the last pair arrives is used.
// One shared unit does all the arithmetic, one operand read per cycle while
// the sequencer is not held: N*N reads for add or subtract and N*N*N for the
// product. Each read passes the operand stores, the term register and the
// accumulator before its result enters the output queue. An element holds
// one of four queue slots from its first read until it leaves, so at most
// four elements are in progress or queued at once. When the receiver stalls,
// the sequencer holds before starting an element that has no free queue
// slot, so nothing is lost. A new load may begin while queued results still
// drain. Reset clears the sequencer, the queue and the operation register
// (add).

module square_matrix_add_sub_mul
    import smas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // a_elem [15:0], b_elem [31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // result_value [34:0], zero fill above
    output logic                  m_tlast
);

    logic [OP_W-1:0]   operation_reg;
    logic              cfg_wr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    issue_t            issue;
    logic [ELEM_W-1:0] a_q, b_q;
    result_t           result;

    // Configuration port: a single register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OPERATION);
    assign prdata = (paddr[2] == REG_OPERATION) ? {{(32 - OP_W){1'b0}}, operation_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg <= OP_ADD;
        end else if (cfg_wr) begin
            operation_reg <= pwdata[OP_W-1:0];
        end
    end

    smas_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (operation_reg),
        .pop       (m_tvalid && m_tready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .issue     (issue)
    );

    smas_ram #(.WIDTH(ELEM_W), .DEPTH(ELEM_COUNT)) u_a_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata[ELEM_W-1:0]),
        .raddr (issue.a_addr),
        .rdata (a_q)
    );

    smas_ram #(.WIDTH(ELEM_W), .DEPTH(ELEM_COUNT)) u_b_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata[2*ELEM_W-1:ELEM_W]),
        .raddr (issue.b_addr),
        .rdata (b_q)
    );

    smas_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (issue.tag),
        .a_q     (a_q),
        .b_q     (b_q),
        .result  (result)
    );

    // Output queue. The sequencer reserves a slot per element before it
    // starts, so a push never meets a full queue.
    logic [RESULT_W:0]     outq_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [OCC_W-1:0]      outq_cnt_reg, outq_cnt_next;
    logic                  push, pop;

    assign push = result.valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        case ({push, pop})
            2'b10:   outq_cnt_next = outq_cnt_reg + 1'b1;
            2'b01:   outq_cnt_next = outq_cnt_reg - 1'b1;
            default: outq_cnt_next = outq_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            outq_cnt_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            outq_cnt_reg <= outq_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            outq_reg[wptr_reg] <= {result.last, result.value};
        end
    end

    assign m_tvalid = (outq_cnt_reg != '0);
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, outq_reg[rptr_reg][RESULT_W-1:0]};
    assign m_tlast  = outq_reg[rptr_reg][RESULT_W];

    // The queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        outq_cnt_reg <= OCC_W'(OUTQ_DEPTH))
        else $error("output queue overflow");

    // A result never arrives at a full queue unless an entry leaves at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (outq_cnt_reg < OCC_W'(OUTQ_DEPTH)) || pop)
        else $error("result pushed into a full output queue");

    // The last pair of a load starts the compute phase, which holds off input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (wr_addr == ADDR_W'(ELEM_COUNT - 1))) |=> !s_tready)
        else $error("input accepted right after the last pair of a load");

endmodule
